// ===== hw/rtl/rts_pkg.sv =====
// Shared types and constants of the RGBA8 tile swizzle.
package rts_pkg;

   // Tile edge in pixels and the width of a row-slot index inside a strip
   localparam int TILE_SIDE = 4;
   localparam int SLOT_W    = 2;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // Pixel format codes; the unused code behaves as full
   localparam logic [1:0] FMT_FULL  = 2'd0;
   localparam logic [1:0] FMT_RGB   = 2'd1;
   localparam logic [1:0] FMT_ALPHA = 2'd2;

   // Last of the eight words of a tile: plane 1, tile row 3
   localparam logic [2:0] LAST_SLOT = 3'd7;

   // Reset values of the configuration registers
   localparam logic [10:0] WIDTH_RESET  = 11'd1024;
   localparam logic [15:0] HEIGHT_RESET = 16'd1024;

   // Which pixels of a tile are real, and whether it closes the image
   typedef struct packed {
      logic [TILE_SIDE-1:0] col_valid;
      logic [TILE_SIDE-1:0] row_valid;
      logic                 last_image;
   } job_info_type;

   // Tile reader status seen by the input side
   typedef struct packed {
      logic active;     // a tile still has reads to issue
      logic releasing;  // its last read issues in this cycle
   } reader_status_type;

   // One result beat
   typedef struct packed {
      logic [63:0] tile_row_word;
      logic        plane_select;
      logic        last_of_tile;
      logic        last_of_image;
   } rsp_entry_type;

endpackage

// ===== hw/rtl/rts_stream_if.sv =====
// Stream channel interfaces: pixel input and tile word output.
interface rts_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_bytes;

   modport source (output valid, output pixel_bytes, input ready);
   modport sink   (input valid, input pixel_bytes, output ready);
endinterface

interface rts_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] tile_row_word;
   logic        plane_select;
   logic        last_of_tile;
   logic        last_of_image;

   modport source (output valid, output tile_row_word, output plane_select,
                   output last_of_tile, output last_of_image, input ready);
   modport sink   (input valid, input tile_row_word, input plane_select,
                   input last_of_tile, input last_of_image, output ready);
endinterface

// ===== hw/rtl/rts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rts_tile_reader.sv =====
// Tile reader: sequences the eight bank reads of a tile and queues result beats.
module rts_tile_reader #(
   parameter int GROUP_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          launch,
   input  rts_pkg::job_info_type         launch_info,
   input  logic [GROUP_W-1:0]            job_group,
   input  logic [31:0]                   bank_rd_data [rts_pkg::TILE_SIDE],
   output logic                          rd_en,
   output logic [GROUP_W+rts_pkg::SLOT_W-1:0] rd_addr,
   output rts_pkg::reader_status_type    status,
   rts_rsp_if.source                     rsp
);

   // Job sequencer
   logic                  active_ff, active_in;
   logic [2:0]            slot_ff, slot_in;
   rts_pkg::job_info_type info_ff, info_in;

   // Read in flight (data arrives from the banks in the cycle after issue)
   logic                  infl_valid_ff;
   logic [2:0]            infl_slot_ff;
   rts_pkg::job_info_type infl_info_ff;

   // Two-entry result queue
   rts_pkg::rsp_entry_type fifo_ff [2];
   rts_pkg::rsp_entry_type entry_in;
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             cnt_ff, cnt_in;

   logic       pop;
   logic [2:0] level;

   // Issue a read only if its data will find room in the queue
   always_comb begin
      pop    = rsp.valid && rsp.ready;
      level  = 3'(cnt_ff) + 3'(infl_valid_ff) - 3'(pop);
      rd_en  = active_ff && (level <= 3'd1);
      rd_addr = {slot_ff[rts_pkg::SLOT_W-1:0], job_group};
      status.active    = active_ff;
      status.releasing = rd_en && (slot_ff == rts_pkg::LAST_SLOT);
   end

   // Sequencer next state; a launch may land on the cycle of the last read
   always_comb begin
      active_in = active_ff;
      slot_in   = slot_ff;
      info_in   = info_ff;
      if (rd_en) begin
         slot_in = slot_ff + 3'd1;
         if (slot_ff == rts_pkg::LAST_SLOT) begin
            active_in = 1'b0;
         end
      end
      if (launch) begin
         active_in = 1'b1;
         slot_in   = '0;
         info_in   = launch_info;
      end
   end

   // Build the result word from the four banks, zeroing padding positions
   always_comb begin
      logic [31:0] px;
      logic [15:0] pair;
      entry_in = '0;
      for (int c = 0; c < rts_pkg::TILE_SIDE; c++) begin
         px   = bank_rd_data[c];
         pair = infl_slot_ff[2] ? px[15:0] : px[31:16];
         if (!(infl_info_ff.col_valid[c]
               && infl_info_ff.row_valid[infl_slot_ff[rts_pkg::SLOT_W-1:0]])) begin
            pair = '0;
         end
         entry_in.tile_row_word[(rts_pkg::TILE_SIDE-1-c)*16 +: 16] = pair;
      end
      entry_in.plane_select  = infl_slot_ff[2];
      entry_in.last_of_tile  = (infl_slot_ff == rts_pkg::LAST_SLOT);
      entry_in.last_of_image = (infl_slot_ff == rts_pkg::LAST_SLOT)
                               && infl_info_ff.last_image;
   end

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ infl_valid_ff;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(infl_valid_ff) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         slot_ff       <= '0;
         infl_valid_ff <= 1'b0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         active_ff     <= active_in;
         slot_ff       <= slot_in;
         infl_valid_ff <= rd_en;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      info_ff      <= info_in;
      infl_slot_ff <= slot_ff;
      infl_info_ff <= info_ff;
      if (infl_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= entry_in;
      end
   end

   // Queue head drives the result channel
   assign rsp.valid         = (cnt_ff != 2'd0);
   assign rsp.tile_row_word = fifo_ff[rd_ptr_ff].tile_row_word;
   assign rsp.plane_select  = fifo_ff[rd_ptr_ff].plane_select;
   assign rsp.last_of_tile  = fifo_ff[rd_ptr_ff].last_of_tile;
   assign rsp.last_of_image = fifo_ff[rd_ptr_ff].last_of_image;

endmodule

// ===== hw/rtl/rgba8_tile_swizzle.sv =====
// Top level of the RGBA8 tile swizzle: raster pixels in, 4x4 tile words out.
//
//   channel  dir  handshake         payload
//   req      in   valid/ready       pixel_bytes[31:0]
//   rsp      out  valid/ready       tile_row_word[63:0], plane_select,
//                                   last_of_tile, last_of_image
//   csr      in   csr_write_enable  csr_index[1:0], csr_write_data[15:0]
//
// A pixel is taken on a valid/ready handshake and written to one of four column banks.
// A tile-completing pixel starts the tile reader, which reads one tile row
// from all four banks per cycle while the result queue has room, and yields
// one result beat per cycle, eight per tile.
// A completing pixel waits while the previous tile still has reads to issue,
// and any pixel waits whose column group is the one being read.
// Reset is synchronous; the line store is not cleared and needs no pass.
// Result stalls back up through a two-beat queue into the reader.
module rgba8_tile_swizzle #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   rts_req_if.sink     req,
   rts_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int CW = $clog2(MAX_WIDTH);           // column counter
   localparam int WW = $clog2(MAX_WIDTH + 1);       // holds MAX_WIDTH
   localparam int EW = (WW > 11) ? WW : 11;         // width compare
   localparam int GW = (CW > 2) ? CW - 2 : 1;       // column group
   localparam int AW = GW + rts_pkg::SLOT_W;        // bank address

   // Configuration registers
   logic [1:0]  pixel_format_ff;
   logic [10:0] image_width_ff;
   logic [15:0] image_height_ff;

   // Raster position
   logic [CW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;

   // Column group of the tile in the reader
   logic [GW-1:0] job_grp_ff;

   logic [EW-1:0] w_ext;
   logic [WW-1:0] w_eff;
   logic [15:0]   h_eff;
   logic          last_col, last_row, trigger, accept, hazard;
   logic [WW-1:0] tx;
   logic [15:0]   sy;
   logic [GW-1:0] col_grp;
   logic [31:0]   argb;

   rts_pkg::job_info_type     launch_info;
   rts_pkg::reader_status_type status;

   logic [31:0]   bank_rd_data [rts_pkg::TILE_SIDE];
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   // Register writes; an index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= rts_pkg::FMT_FULL;
         image_width_ff  <= rts_pkg::WIDTH_RESET;
         image_height_ff <= rts_pkg::HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rts_pkg::CSR_PIXEL_FORMAT: pixel_format_ff <= csr_write_data[1:0];
            rts_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[10:0];
            rts_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Effective size: zero acts as one, width clamps to the store
   always_comb begin
      w_ext = EW'(image_width_ff);
      if (w_ext == '0) begin
         w_ext = EW'(1);
      end else if (w_ext > EW'(MAX_WIDTH)) begin
         w_ext = EW'(MAX_WIDTH);
      end
      w_eff = WW'(w_ext);
      h_eff = (image_height_ff == '0) ? 16'd1 : image_height_ff;
   end

   // Position flags and tile geometry
   always_comb begin
      last_col = WW'(col_ff) >= (w_eff - WW'(1));
      last_row = row_ff >= (h_eff - 16'd1);
      trigger  = ((col_ff[1:0] == 2'd3) || last_col)
                 && ((row_ff[1:0] == 2'd3) || last_row);
      tx       = WW'(col_ff) & ~WW'(3);
      sy       = row_ff & ~16'd3;
      col_grp  = GW'(col_ff >> 2);
      for (int c = 0; c < rts_pkg::TILE_SIDE; c++) begin
         launch_info.col_valid[c] = (tx + WW'(c)) < w_eff;
      end
      for (int r = 0; r < rts_pkg::TILE_SIDE; r++) begin
         launch_info.row_valid[r] = ({1'b0, sy} + 17'(r)) < {1'b0, h_eff};
      end
      launch_info.last_image = last_col && last_row;
   end

   // Interlock: keep the group under read intact, one tile in the reader
   always_comb begin
      hazard    = status.active && !status.releasing && (col_grp == job_grp_ff);
      req.ready = !hazard && !(trigger && status.active && !status.releasing);
      accept    = req.valid && req.ready;
   end

   // Format expansion to A,R,G,B
   always_comb begin
      case (pixel_format_ff)
         rts_pkg::FMT_RGB:   argb = {8'hFF, req.pixel_bytes[31:8]};
         rts_pkg::FMT_ALPHA: argb = {req.pixel_bytes[31:24], 24'hFF_FFFF};
         default:            argb = req.pixel_bytes;
      endcase
   end

   // Raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? 16'd0 : row_ff + 16'd1;
      end else begin
         col_in = col_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && trigger) begin
         job_grp_ff <= col_grp;
      end
   end

   // Line store: one bank per column lane, addressed by row slot and group
   for (genvar b = 0; b < rts_pkg::TILE_SIDE; b++) begin : g_bank
      rts_ram #(
         .WIDTH (32),
         .DEPTH (1 << AW)
      ) u_bank (
         .clock   (clock),
         .wr_en   (accept && (col_ff[1:0] == 2'(b))),
         .wr_addr ({row_ff[rts_pkg::SLOT_W-1:0], col_grp}),
         .wr_data (argb),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (bank_rd_data[b])
      );
   end

   rts_tile_reader #(
      .GROUP_W (GW)
   ) u_reader (
      .clock        (clock),
      .reset        (reset),
      .launch       (accept && trigger),
      .launch_info  (launch_info),
      .job_group    (job_grp_ff),
      .bank_rd_data (bank_rd_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .status       (status),
      .rsp          (rsp)
   );

`ifndef SYNTHESIS
   // A pixel is never written into the group whose reads are still pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept && status.active && !status.releasing |-> col_grp != job_grp_ff)
      else $error("pixel written into tile under read");

   // A new tile starts only when the reader is free or finishing
   a_one_job: assert property (@(posedge clock) disable iff (reset)
      accept && trigger |-> !status.active || status.releasing)
      else $error("tile launched over a busy reader");

   // Image end is flagged only on the final G/B word of a tile
   a_last_image: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last_of_image |-> rsp.last_of_tile && rsp.plane_select)
      else $error("last_of_image outside the last word of a tile");

   // A read is issued only for a tile that is in the reader
   a_read_job: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> status.active)
      else $error("bank read without a tile");
`endif

endmodule

// ===== tb/tb_rgba8_tile_swizzle.sv =====
// Self-checking testbench of the RGBA8 tile swizzle: directed table, then random images.
`timescale 1ns / 100ps

module tb_rgba8_tile_swizzle;

   localparam int LINE_MAX      = 1024;   // block's MAX_WIDTH
   localparam int SETTLE_CYCLES = 12;     // reader plus output queue, with margin
   localparam int DRAIN_CYCLES  = 24;
   localparam int WIDE_ITEMS    = 128;    // pixels of the wide row before it is cut
   localparam int SMALL_ITEMS   = 330;
   localparam int QUIET_TAIL    = 60;
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   // Codes the package leaves unnamed
   localparam logic [1:0] FMT_SPARE  = 2'd3;   // behaves as full
   localparam logic [1:0] CSR_SPARE  = 2'd3;   // no register behind it
   localparam logic [7:0] OPAQUE     = 8'hFF;
   localparam int         LAST_BEAT  = 7;

   typedef enum logic [1:0] {
      SK_CSR,
      SK_PIXEL,
      SK_PIXEL_TYPED
   } stim_kind_type;

   typedef struct packed {
      stim_kind_type kind;
      logic [1:0]    csr_sel;
      logic [31:0]   value;
      logic [15:0]   ar_pair;   // typed rows: A/R pair of the lone pixel
      logic [15:0]   gb_pair;   // typed rows: G/B pair of the lone pixel
   } stim_row_type;

   localparam int DIRECTED_ROWS = 39;

   // Typed rows all sit in 1x1 images, so the tile is one pixel and zeros
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{SK_CSR,         rts_pkg::CSR_PIXEL_FORMAT, 32'(rts_pkg::FMT_FULL),  16'h0000, 16'h0000},
      '{SK_CSR,         rts_pkg::CSR_IMAGE_WIDTH,  32'd1,          16'h0000, 16'h0000},
      '{SK_CSR,         rts_pkg::CSR_IMAGE_HEIGHT, 32'd1,          16'h0000, 16'h0000},
      '{SK_PIXEL_TYPED, rts_pkg::CSR_PIXEL_FORMAT, 32'hFFFF_FFFF,  16'hFFFF, 16'hFFFF},
      '{SK_PIXEL_TYPED, rts_pkg::CSR_PIXEL_FORMAT, 32'h0000_0000,  16'h0000, 16'h0000},
      '{SK_PIXEL_TYPED, rts_pkg::CSR_PIXEL_FORMAT, 32'h1234_5678,  16'h1234, 16'h5678},
      '{SK_CSR,         rts_pkg::CSR_PIXEL_FORMAT, 32'(rts_pkg::FMT_RGB),   16'h0000, 16'h0000},
      '{SK_PIXEL_TYPED, rts_pkg::CSR_PIXEL_FORMAT, 32'hA1B2_C3D4,  16'hFFA1, 16'hB2C3},
      '{SK_CSR,         rts_pkg::CSR_PIXEL_FORMAT, 32'(rts_pkg::FMT_ALPHA), 16'h0000, 16'h0000},
      '{SK_PIXEL_TYPED, rts_pkg::CSR_PIXEL_FORMAT, 32'h5A6B_7C8D,  16'h5AFF, 16'hFFFF},
      '{SK_CSR,         rts_pkg::CSR_PIXEL_FORMAT, 32'(FMT_SPARE),  16'h0000, 16'h0000},
      '{SK_PIXEL_TYPED, rts_pkg::CSR_PIXEL_FORMAT, 32'h0F1E_2D3C,  16'h0F1E, 16'h2D3C},
      '{SK_CSR,         CSR_SPARE,                 32'h0000_FFFF,  16'h0000, 16'h0000},
      '{SK_PIXEL_TYPED, rts_pkg::CSR_PIXEL_FORMAT, 32'h96A5_B4C3,  16'h96A5, 16'hB4C3},
      '{SK_CSR,         rts_pkg::CSR_IMAGE_WIDTH,  32'd0,          16'h0000, 16'h0000},
      '{SK_CSR,         rts_pkg::CSR_IMAGE_HEIGHT, 32'd0,          16'h0000, 16'h0000},
      '{SK_PIXEL_TYPED, rts_pkg::CSR_PIXEL_FORMAT, 32'h89AB_CDEF,  16'h89AB, 16'hCDEF},
      // 3x2 image: one partial tile in both directions
      '{SK_CSR,         rts_pkg::CSR_PIXEL_FORMAT, 32'(rts_pkg::FMT_FULL),  16'h0000, 16'h0000},
      '{SK_CSR,         rts_pkg::CSR_IMAGE_WIDTH,  32'd3,          16'h0000, 16'h0000},
      '{SK_CSR,         rts_pkg::CSR_IMAGE_HEIGHT, 32'd2,          16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h0102_0304,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h1112_1314,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h2122_2324,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'hF1E2_D3C4,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'hE5D6_C7B8,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'hD9CA_BBAC,  16'h0000, 16'h0000},
      // tallest image, cut short by a height change in its second strip
      '{SK_CSR,         rts_pkg::CSR_IMAGE_WIDTH,  32'd2,          16'h0000, 16'h0000},
      '{SK_CSR,         rts_pkg::CSR_IMAGE_HEIGHT, 32'h0000_FFFF,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h8001_7F02,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h4003_BF04,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h2005_DF06,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h1007_EF08,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h0809_F70A,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h040B_FB0C,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h020D_FD0E,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h010F_FE10,  16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'hAA55_55AA,  16'h0000, 16'h0000},
      '{SK_CSR,         rts_pkg::CSR_IMAGE_HEIGHT, 32'd5,          16'h0000, 16'h0000},
      '{SK_PIXEL,       rts_pkg::CSR_PIXEL_FORMAT, 32'h55AA_AA55,  16'h0000, 16'h0000}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   rts_req_if req_chan ();
   rts_rsp_if rsp_chan ();

   rgba8_tile_swizzle #(
      .MAX_WIDTH (LINE_MAX)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .rsp              (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Predictor state: register copies, strip store and raster position
   logic [1:0]    cfg_format = rts_pkg::FMT_FULL;
   logic [10:0]   cfg_width  = rts_pkg::WIDTH_RESET;
   logic [15:0]   cfg_height = rts_pkg::HEIGHT_RESET;
   logic [31:0]   strip_copy [0:4*LINE_MAX-1];
   logic [9:0]    col_q = '0;
   logic [15:0]   row_q = '0;
   rts_pkg::rsp_entry_type tile_beats [8];
   int            tile_beat_count;

   rts_pkg::rsp_entry_type pending_words [$];
   rts_pkg::rsp_entry_type want_word;
   int            fail_count = 0;
   logic          quiet_tail = 1'b0;

   int            send_calm_left  = 0;
   int            rsp_stall_left  = 0;
   int            rsp_calm_left   = 0;

   function automatic logic [31:0] expand_argb(input logic [1:0] fmt, input logic [31:0] px);
      case (fmt)
         rts_pkg::FMT_RGB:   return {OPAQUE, px[31:8]};
         rts_pkg::FMT_ALPHA: return {px[31:24], OPAQUE, OPAQUE, OPAQUE};
         default:            return px;
      endcase
   endfunction

   function automatic logic [10:0] effective_width(input logic [10:0] w);
      if (w == 11'd0)
         return 11'd1;
      if (w > 11'(LINE_MAX))
         return 11'(LINE_MAX);
      return w;
   endfunction

   function automatic logic [15:0] effective_height(input logic [15:0] h);
      return (h == 16'd0) ? 16'd1 : h;
   endfunction

   // One accepted pixel: store it, emit the tile's eight words if it closes one
   task automatic predict_tile_words(input logic [31:0] px);
      logic [10:0] w;
      logic [15:0] h;
      logic        last_c;
      logic        last_r;
      logic [31:0] argb;
      logic [15:0] pair;
      logic [63:0] word;
      int          tx;
      int          sy;
      int          x;
      int          y;
      w = effective_width(cfg_width);
      h = effective_height(cfg_height);
      strip_copy[int'(row_q[1:0]) * LINE_MAX + int'(col_q)] = expand_argb(cfg_format, px);
      last_c = ({1'b0, col_q} >= w - 11'd1);
      last_r = (row_q >= h - 16'd1);
      tile_beat_count = 0;
      if ((col_q[1:0] == 2'd3 || last_c) && (row_q[1:0] == 2'd3 || last_r)) begin
         tx = int'(col_q) & ~3;
         sy = int'(row_q) & ~3;
         for (int n = 0; n < 8; n++) begin
            word = '0;
            for (int c = 0; c < rts_pkg::TILE_SIDE; c++) begin
               x = tx + c;
               y = sy + (n % rts_pkg::TILE_SIDE);
               pair = '0;
               if (x < int'(w) && y < int'(h)) begin
                  argb = strip_copy[(n % rts_pkg::TILE_SIDE) * LINE_MAX + x];
                  pair = (n >= rts_pkg::TILE_SIDE) ? argb[15:0] : argb[31:16];
               end
               word = {word[47:0], pair};
            end
            tile_beats[n] = '{tile_row_word: word,
                              plane_select:  (n >= rts_pkg::TILE_SIDE),
                              last_of_tile:  (n == LAST_BEAT),
                              last_of_image: (n == LAST_BEAT) && last_c && last_r};
         end
         tile_beat_count = 8;
      end
      // raster advance; a counter past a shrunk limit wraps at once
      if (last_c) begin
         col_q = '0;
         row_q = last_r ? 16'd0 : row_q + 16'd1;
      end else begin
         col_q = col_q + 10'd1;
      end
   endtask

   // Send one pixel beat, with an optional gap first; typed rows bring their own words
   task automatic push_pixel(input logic [31:0] px, input logic typed,
                             input logic [15:0] ar, input logic [15:0] gb);
      int gap;
      rts_pkg::rsp_entry_type typed_word;
      gap = 0;
      if (!quiet_tail) begin
         if (send_calm_left != 0)
            send_calm_left--;
         else if ($urandom_range(0, 15) == 0)
            send_calm_left = $urandom_range(20, 60);
         else if ($urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 10);
      end
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.pixel_bytes <= px;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_tile_words(px);
      for (int n = 0; n < tile_beat_count; n++) begin
         if (typed) begin
            typed_word = tile_beats[n];
            typed_word.tile_row_word = (n == 0)                  ? {ar, 48'h0} :
                                       (n == rts_pkg::TILE_SIDE) ? {gb, 48'h0} : 64'h0;
            typed_word.last_of_image = (n == LAST_BEAT);
            pending_words.push_back(typed_word);
         end else begin
            pending_words.push_back(tile_beats[n]);
         end
      end
   endtask

   // Stop sending and wait for the block to go idle
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] sel, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= data;
      case (sel)
         rts_pkg::CSR_PIXEL_FORMAT: cfg_format = data[1:0];
         rts_pkg::CSR_IMAGE_WIDTH:  cfg_width  = data[10:0];
         rts_pkg::CSR_IMAGE_HEIGHT: cfg_height = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: random stall bursts, calm stretches, none at the tail
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (quiet_tail) begin
         rsp_chan.ready <= 1'b1;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_calm_left != 0) begin
         rsp_calm_left--;
         rsp_chan.ready <= 1'b1;
      end else begin
         case ($urandom_range(0, 9))
            0: begin
               rsp_stall_left = $urandom_range(1, 10) - 1;
               rsp_chan.ready <= 1'b0;
            end
            1: begin
               rsp_calm_left = $urandom_range(20, 60);
               rsp_chan.ready <= 1'b1;
            end
            default: rsp_chan.ready <= 1'b1;
         endcase
      end
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Result beat checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_words.size() == 0) begin
            $error("tile word beat with none expected: %h", rsp_chan.tile_row_word);
            fail_count++;
         end else begin
            want_word = pending_words.pop_front();
            check_field("tile_row_word", want_word.tile_row_word, rsp_chan.tile_row_word);
            check_field("plane_select", 64'(want_word.plane_select), 64'(rsp_chan.plane_select));
            check_field("last_of_tile", 64'(want_word.last_of_tile), 64'(rsp_chan.last_of_tile));
            check_field("last_of_image", 64'(want_word.last_of_image),
                        64'(rsp_chan.last_of_image));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("rgba8_tile_swizzle regression: fail");
      $finish;
   end

   initial begin
      logic [10:0] img_w;
      logic [15:0] img_h;
      int          pixels;
      int          break_at;
      int          sent;
      int          small_sent;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.pixel_bytes <= '0;
      csr_write_enable     <= 1'b0;
      csr_index            <= rts_pkg::CSR_PIXEL_FORMAT;
      csr_write_data       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         case (DIRECTED[i].kind)
            SK_CSR: begin
               settle();
               write_csr(DIRECTED[i].csr_sel, DIRECTED[i].value[15:0]);
            end
            SK_PIXEL_TYPED:
               push_pixel(DIRECTED[i].value, 1'b1, DIRECTED[i].ar_pair, DIRECTED[i].gb_pair);
            default:
               push_pixel(DIRECTED[i].value, 1'b0, '0, '0);
         endcase
      end

      // Widest image, one row tall; width may sit above the clamp.
      // The row is cut by a width shrink, so the column counter wraps at once.
      settle();
      write_csr(rts_pkg::CSR_PIXEL_FORMAT, 16'($urandom_range(0, 3)));
      write_csr(rts_pkg::CSR_IMAGE_WIDTH,
                $urandom_range(0, 1) ? 16'(LINE_MAX) : 16'($urandom_range(LINE_MAX + 1, 2047)));
      write_csr(rts_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      for (int i = 0; i < WIDE_ITEMS; i++)
         push_pixel($urandom(), 1'b0, '0, '0);
      settle();
      write_csr(rts_pkg::CSR_IMAGE_WIDTH, 16'($urandom_range(1, WIDE_ITEMS)));
      do push_pixel($urandom(), 1'b0, '0, '0); while (col_q != 0 || row_q != 0);

      // Small random images, some cut by a shrink of width or height mid-image
      small_sent = 0;
      while (small_sent < SMALL_ITEMS) begin
         if (small_sent >= SMALL_ITEMS - QUIET_TAIL)
            quiet_tail = 1'b1;
         case ($urandom_range(0, 9))
            0:       img_w = 11'd0;
            1:       img_w = 11'($urandom_range(10, 24));
            default: img_w = 11'($urandom_range(1, 9));
         endcase
         case ($urandom_range(0, 9))
            0:       img_h = 16'd0;
            1:       img_h = 16'($urandom_range(8, 14));
            default: img_h = 16'($urandom_range(1, 7));
         endcase
         if (img_w > 11'd9 && img_h > 16'd7)
            img_h = 16'($urandom_range(1, 4));
         settle();
         write_csr(rts_pkg::CSR_PIXEL_FORMAT, 16'($urandom_range(0, 3)));
         write_csr(rts_pkg::CSR_IMAGE_WIDTH, 16'(img_w));
         write_csr(rts_pkg::CSR_IMAGE_HEIGHT, img_h);
         img_w = effective_width(img_w);
         img_h = effective_height(img_h);
         pixels = int'(img_w) * int'(img_h);
         break_at = (pixels > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, pixels - 1) : 0;
         sent = 0;
         do begin
            push_pixel($urandom(), 1'b0, '0, '0);
            sent++;
            small_sent++;
            if (sent == break_at) begin
               settle();
               if ($urandom_range(0, 1))
                  write_csr(rts_pkg::CSR_IMAGE_WIDTH, 16'($urandom_range(1, int'(img_w))));
               else
                  write_csr(rts_pkg::CSR_IMAGE_HEIGHT, 16'($urandom_range(1, int'(img_h))));
            end
         end while (col_q != 0 || row_q != 0);
      end

      // Drain and report
      req_chan.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words.size() == 0)
         $display("rgba8_tile_swizzle regression: pass");
      else
         $display("rgba8_tile_swizzle regression: fail");
      $finish;
   end

endmodule
